// ===== hdl/cti_pkg.sv =====
package cti_pkg;

	// Field widths of the request, response and register words.
	localparam int FUNC_W        = 1;
	localparam int ENTRY_INDEX_W = 10;
	localparam int ENTRY_VALUE_W = 16;
	localparam int FREQUENCY_W   = 24;
	localparam int AMPLITUDE_W   = 16;
	localparam int SCALE_W       = 24;
	localparam int SIZE_W        = 10;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Register select bit, paddr[2].
	localparam logic REG_INDEX_SCALE = 1'b0;
	localparam logic REG_TABLE_SIZE  = 1'b1;

	localparam logic [SCALE_W-1:0] INDEX_SCALE_RST = 24'd65536;
	localparam logic [SIZE_W-1:0]  TABLE_SIZE_RST  = 10'd512;

	// Request function codes.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Doubled Catmull-Rom weights in Q.16 fit in this signed width.
	localparam int WGT_W = 20;

	typedef logic signed [WGT_W-1:0] weight_t;

endpackage

// ===== hdl/cti_ram.sv =====
module cti_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/cubic_table_interpolator.sv =====
// Channel  Dir     Handshake              Word
// req      in      req_valid / req_stall  func, entry_index, entry_value, frequency
// rsp      out     rsp_valid / rsp_stall  amplitude
// cfg      in/out  APB, pready tied high  index_scale at 0x0, table_size at 0x4
//
// Nine register stages; one word enters per cycle while req_stall is low, and a
// query word returns its amplitude from the last stage on rsp.
// The rate is set by the four table copies, each with one write and one read port,
// which serve the four neighbors of a query in the same cycle.
// A table write commits from stage 4 and produces no rsp word.
// Reset clears the stage valids and presets the config registers, not the table.
// A stall on rsp holds the last stage and every full stage behind it up to the first
// empty one; req_stall rises only when all nine stages are full and rsp is stalled.
module cubic_table_interpolator #(
	parameter int TABLE_DEPTH = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [cti_pkg::FUNC_W-1:0]          func,
	input  logic [cti_pkg::ENTRY_INDEX_W-1:0]   entry_index,
	input  logic [cti_pkg::ENTRY_VALUE_W-1:0]   entry_value,
	input  logic [cti_pkg::FREQUENCY_W-1:0]     frequency,

	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [cti_pkg::AMPLITUDE_W-1:0]     amplitude,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cti_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [cti_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [cti_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int AW      = $clog2(TABLE_DEPTH);
	localparam int PW      = cti_pkg::WGT_W + SAMPLE_BITS + 1;
	localparam int ACC_W   = PW + 2;
	localparam int RES_W   = ACC_W - 17;
	localparam int RECIP_W = 22;
	// floor(2^24 / depth); the quotient it gives is low by at most one.
	localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((1 << 24) / TABLE_DEPTH);
	localparam logic [16:0]        DEPTH_V = 17'(TABLE_DEPTH);
	localparam logic [RES_W-1:0]   SAMPLE_MAX = RES_W'({SAMPLE_BITS{1'b1}});

	// ---------------------------------------------------------------- registers
	logic [cti_pkg::SCALE_W-1:0] index_scale_q;
	logic [cti_pkg::SIZE_W-1:0]  table_size_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_scale_q <= cti_pkg::INDEX_SCALE_RST;
			table_size_q  <= cti_pkg::TABLE_SIZE_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				cti_pkg::REG_INDEX_SCALE: index_scale_q <= pwdata[cti_pkg::SCALE_W-1:0];
				cti_pkg::REG_TABLE_SIZE:  table_size_q  <= pwdata[cti_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			cti_pkg::REG_INDEX_SCALE: prdata = cti_pkg::APB_DATA_W'(index_scale_q);
			cti_pkg::REG_TABLE_SIZE:  prdata = cti_pkg::APB_DATA_W'(table_size_q);
			default:                  prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- flow control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en1, en2, en3, en4, en5, en6, en7, en8, en9;

	// A stage loads when it is empty or its word moves on in the same cycle.
	assign en9 = !v_s9 || !rsp_stall;
	assign en8 = !v_s8 || en9;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign req_stall = !en1;
	assign rsp_valid = v_s9;

	// ---------------------------------------------------------------- payload
	logic                               func_s1, func_s2, func_s3, func_s4;
	logic [cti_pkg::ENTRY_INDEX_W-1:0]  eidx_s1, eidx_s2, eidx_s3, eidx_s4;
	logic [cti_pkg::ENTRY_VALUE_W-1:0]  eval_s1, eval_s2, eval_s3, eval_s4;
	logic [31:0]                        pos_s1;
	logic [15:0]                        u_s2, u_s3, u_s4;
	logic                               oor_s2, oor_s3, oor_s4, oor_s5, oor_s6, oor_s7,
	                                    oor_s8;
	logic [9:0]                         ilo_s2;
	logic [31:0]                        uu_s2;
	logic [7:0]                         q_s2;
	logic [15:0]                        t2_s3, t2_s4;
	logic [9:0]                         rpre_s3, r_s4;
	logic [31:0]                        ut2_s4;
	cti_pkg::weight_t                   w0_s5, w1_s5, w2_s5, w3_s5;
	logic signed [PW-1:0]               p0_s6, p1_s6, p2_s6, p3_s6;
	logic signed [PW:0]                 p01_s7, p23_s7;
	logic signed [ACC_W-1:0]            acc_s8;
	logic [cti_pkg::AMPLITUDE_W-1:0]    amp_s9;

	// Stage 1 inputs: the position product.
	logic [47:0] pos_full;
	assign pos_full = 48'(frequency) * 48'(index_scale_q);

	// Stage 2 inputs: index split, range check, fraction square, index quotient.
	logic [15:0] i_c1;
	logic [31:0] qprod_c1;
	assign i_c1     = pos_s1[31:16];
	assign qprod_c1 = 32'(pos_s1[25:16]) * 32'(RECIP);

	// Stage 3 inputs: rounded t^2 and index remainder before correction.
	logic [31:0] t2sum_c2;
	logic [24:0] qd_c2;
	assign t2sum_c2 = uu_s2 + 32'h0000_8000;
	assign qd_c2    = 25'(q_s2) * 25'(DEPTH_V);

	// Stage 4 inputs: u * t^2 and the corrected index remainder.
	logic [9:0] r_c3;
	assign r_c3 = ({7'b0, rpre_s3} >= DEPTH_V) ? (rpre_s3 - DEPTH_V[9:0]) : rpre_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			// Table writes end in stage 4; only query words go further.
			if (en5) v_s5 <= v_s4 && (func_s4 == cti_pkg::FUNC_QUERY);
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
			if (en9) v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1 <= func;
			eidx_s1 <= entry_index;
			eval_s1 <= entry_value;
			pos_s1  <= pos_full[47:16];
		end
		if (en2) begin
			func_s2 <= func_s1;
			eidx_s2 <= eidx_s1;
			eval_s2 <= eval_s1;
			u_s2    <= pos_s1[15:0];
			ilo_s2  <= pos_s1[25:16];
			oor_s2  <= i_c1 > 16'(table_size_q);
			uu_s2   <= 32'(pos_s1[15:0]) * 32'(pos_s1[15:0]);
			q_s2    <= qprod_c1[31:24];
		end
		if (en3) begin
			func_s3 <= func_s2;
			eidx_s3 <= eidx_s2;
			eval_s3 <= eval_s2;
			u_s3    <= u_s2;
			oor_s3  <= oor_s2;
			t2_s3   <= t2sum_c2[31:16];
			rpre_s3 <= ilo_s2 - qd_c2[9:0];
		end
		if (en4) begin
			func_s4 <= func_s3;
			eidx_s4 <= eidx_s3;
			eval_s4 <= eval_s3;
			u_s4    <= u_s3;
			oor_s4  <= oor_s3;
			t2_s4   <= t2_s3;
			ut2_s4  <= 32'(u_s3) * 32'(t2_s3);
			r_s4    <= r_c3;
		end
	end

	// ---------------------------------------------------------------- weights and table
	logic [31:0]      t3sum_c4;
	logic [15:0]      t3_c4;
	cti_pkg::weight_t us_c4, t2s_c4, t3s_c4;
	cti_pkg::weight_t w0_c4, w1_c4, w2_c4, w3_c4;

	assign t3sum_c4 = ut2_s4 + 32'h0000_8000;
	assign t3_c4    = t3sum_c4[31:16];
	assign us_c4    = cti_pkg::WGT_W'(u_s4);
	assign t2s_c4   = cti_pkg::WGT_W'(t2_s4);
	assign t3s_c4   = cti_pkg::WGT_W'(t3_c4);

	assign w0_c4 = t2s_c4 + t2s_c4 - us_c4 - t3s_c4;
	assign w1_c4 = 20'sd131072 - 20'sd5 * t2s_c4 + 20'sd3 * t3s_c4;
	assign w2_c4 = us_c4 + 20'sd4 * t2s_c4 - 20'sd3 * t3s_c4;
	assign w3_c4 = t3s_c4 - t2s_c4;

	logic                   tab_we;
	logic [AW-1:0]          tab_waddr;
	logic [SAMPLE_BITS-1:0] tab_wdata;
	logic [AW-1:0]          tab_raddr [4];
	logic [SAMPLE_BITS-1:0] tab_rdata [4];

	assign tab_we = en5 && v_s4 && (func_s4 == cti_pkg::FUNC_WRITE)
		&& ({7'b0, eidx_s4} < DEPTH_V);
	assign tab_waddr = AW'(eidx_s4);
	assign tab_wdata = SAMPLE_BITS'(eval_s4);

	// Each copy holds the whole table and serves one of the four neighbors.
	for (genvar k = 0; k < 4; k++) begin : g_copy
		logic [16:0] a_sum;
		logic [16:0] a_wrap;

		assign a_sum  = {7'b0, r_s4} + 17'(k);
		assign a_wrap = (a_sum >= DEPTH_V) ? (a_sum - DEPTH_V) : a_sum;
		assign tab_raddr[k] = AW'(a_wrap);

		cti_ram #(
			.WIDTH(SAMPLE_BITS),
			.DEPTH(TABLE_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (tab_we),
			.waddr(tab_waddr),
			.wdata(tab_wdata),
			.re   (en5),
			.raddr(tab_raddr[k]),
			.rdata(tab_rdata[k])
		);
	end

	// ---------------------------------------------------------------- blend
	logic signed [SAMPLE_BITS:0] tx0, tx1, tx2, tx3;
	assign tx0 = $signed({1'b0, tab_rdata[0]});
	assign tx1 = $signed({1'b0, tab_rdata[1]});
	assign tx2 = $signed({1'b0, tab_rdata[2]});
	assign tx3 = $signed({1'b0, tab_rdata[3]});

	logic                    acc_pos_c8;
	logic [ACC_W-1:0]        rnd_c8;
	logic [RES_W-1:0]        res_c8;
	logic [RES_W-1:0]        sat_c8;

	assign acc_pos_c8 = !acc_s8[ACC_W-1] && (acc_s8 != '0);
	assign rnd_c8     = $unsigned(acc_s8) + ACC_W'(65536);
	assign res_c8     = rnd_c8[ACC_W-1:17];
	assign sat_c8     = (res_c8 > SAMPLE_MAX) ? SAMPLE_MAX : res_c8;

	always_ff @(posedge clk) begin
		if (en5) begin
			w0_s5  <= w0_c4;
			w1_s5  <= w1_c4;
			w2_s5  <= w2_c4;
			w3_s5  <= w3_c4;
			oor_s5 <= oor_s4;
		end
		if (en6) begin
			p0_s6  <= PW'(w0_s5) * PW'(tx0);
			p1_s6  <= PW'(w1_s5) * PW'(tx1);
			p2_s6  <= PW'(w2_s5) * PW'(tx2);
			p3_s6  <= PW'(w3_s5) * PW'(tx3);
			oor_s6 <= oor_s5;
		end
		if (en7) begin
			p01_s7 <= (PW+1)'(p0_s6) + (PW+1)'(p1_s6);
			p23_s7 <= (PW+1)'(p2_s6) + (PW+1)'(p3_s6);
			oor_s7 <= oor_s6;
		end
		if (en8) begin
			acc_s8 <= ACC_W'(p01_s7) + ACC_W'(p23_s7);
			oor_s8 <= oor_s7;
		end
		if (en9) begin
			if (oor_s8 || !acc_pos_c8) begin
				amp_s9 <= '0;
			end else begin
				amp_s9 <= cti_pkg::AMPLITUDE_W'(sat_c8);
			end
		end
	end

	assign amplitude = amp_s9;

endmodule

// ===== hdl/cti_checker.sv =====
module cti_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_stall,
	input logic                                rsp_valid,
	input logic                                rsp_stall,
	input logic [cti_pkg::AMPLITUDE_W-1:0]     amplitude,
	input logic                                psel,
	input logic                                penable,
	input logic                                pwrite,
	input logic [cti_pkg::APB_ADDR_W-1:0]      paddr,
	input logic [cti_pkg::APB_DATA_W-1:0]      pwdata,
	input logic [cti_pkg::APB_DATA_W-1:0]      prdata,
	input logic                                pready
);

	// Back pressure on req only ever comes from a held word on rsp.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("req_stall without a stalled rsp word");

	// A register read right after a write returns the written value, cut to width.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready)
		##1 (psel && !pwrite && (paddr[2] == $past(paddr[2])))
		|-> (prdata == (($past(paddr[2]) == cti_pkg::REG_TABLE_SIZE)
			? cti_pkg::APB_DATA_W'($past(pwdata[cti_pkg::SIZE_W-1:0]))
			: cti_pkg::APB_DATA_W'($past(pwdata[cti_pkg::SCALE_W-1:0])))))
		else $error("register read does not return the last write");

	a_cfg_width: assert property (@(posedge clk) disable iff (!arst_n)
		(paddr[2] == cti_pkg::REG_TABLE_SIZE) |-> (prdata[31:cti_pkg::SIZE_W] == '0))
		else $error("table_size reads back bits above its width");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(amplitude)))
		else $error("stalled rsp word changed or dropped");

endmodule

bind cubic_table_interpolator cti_checker u_cti_checker (.*);
